// ===== rtl/core/vps_pkg.sv =====
// Shared types and constants for the vertex projection pipeline.
// Used by vertex_projection_to_screen; no dependencies.
package vps_pkg;

    localparam int COORD_W = 32;
    localparam int SIZE_W  = 13;
    localparam int PROD_W  = 48;
    localparam int CLIP_W  = 50;
    localparam int NUM_W   = 65;
    localparam int MAG_W   = 64;
    localparam int DEN_W   = 51;
    localparam int QUO_W   = 15;
    localparam int CMP_W   = DEN_W + QUO_W;
    localparam int DIV_STAGES = QUO_W + 1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_XFORM = 1'b1;

    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;

    localparam logic signed [CLIP_W-1:0] W_MIN_Q = 50'sd656;
    localparam logic signed [COORD_W-1:0] Q_ONE  = 32'sh0001_0000;

    typedef struct packed {
        logic [MAG_W-1:0] rx;
        logic [MAG_W-1:0] ry;
        logic [QUO_W-1:0] qx;
        logic [QUO_W-1:0] qy;
        logic [DEN_W-1:0] d;
        logic             negx;
        logic             negy;
        logic             satx;
        logic             saty;
        logic             behind;
        logic             nc;
        logic [COORD_W-1:0] dw;
    } vps_div_t;

endpackage

// ===== rtl/core/vertex_projection_to_screen.sv =====
// Vertex transform, perspective divide and viewport mapping pipeline.
// Depends on vps_pkg.
//
// One transaction per clock is accepted and one result per clock delivered when the
// output is not stalled; a vertex result passes the multiply, sum, viewport-scale and
// range-check stages, then the 15-stage restoring divider that forms the screen
// coordinates, and then the output register.
// Coefficient loads take effect at acceptance and give no result; every stage holds
// its own valid bit and moves when the stage after it is free.
module vertex_projection_to_screen
    import vps_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [SIZE_W-1:0]         cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      command,
    input  logic [3:0]                coef_index,
    input  logic signed [COORD_W-1:0] coef_value,
    input  logic signed [COORD_W-1:0] vertex_x,
    input  logic signed [COORD_W-1:0] vertex_y,
    input  logic signed [COORD_W-1:0] vertex_z,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [15:0]        screen_x,
    output logic signed [15:0]        screen_y,
    output logic signed [COORD_W-1:0] depth_w,
    output logic                      behind_flag,
    output logic                      near_clip
);

    localparam int NSTG = 4 + DIV_STAGES;
    localparam int DIV0 = 3;
    localparam int OUTS = NSTG - 1;

    logic [SIZE_W-1:0]         width_reg, height_reg;
    logic signed [COORD_W-1:0] mat_reg [16];
    logic [NSTG-1:0]           v_reg;
    logic [NSTG-1:0]           en;

    logic signed [PROD_W-1:0]  prod_reg [4][3];
    logic signed [COORD_W-1:0] tr_reg [4];
    logic signed [CLIP_W-1:0]  clip_reg [4];
    logic signed [NUM_W-1:0]   nx_reg, ny_reg;
    logic [DEN_W-1:0]          d_reg;
    logic                      behind_reg, nc_reg;
    logic [COORD_W-1:0]        dw_reg;
    vps_div_t                  div_reg [DIV_STAGES];
    vps_div_t                  div_next [DIV_STAGES];
    vps_div_t                  div_first;

    logic signed [15:0]        sx_reg, sy_reg;
    logic signed [COORD_W-1:0] dwo_reg;
    logic                      bh_reg, nco_reg;

    logic accept;
    assign accept = in_valid && in_ready;

    always_comb
    begin
        en[OUTS] = !v_reg[OUTS] || out_ready;
        for (int i = OUTS - 1; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end
    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default:           width_reg  <= width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                mat_reg[i] <= (i % 5 == 0) ? Q_ONE : '0;
            end
        end
        else if (accept && command == CMD_LOAD)
        begin
            mat_reg[coef_index] <= coef_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= accept && command == CMD_XFORM;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Stage 1: twelve products
    logic signed [2*COORD_W-1:0] prod [4][3];
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            prod[r][0] = mat_reg[r] * vertex_x;
            prod[r][1] = mat_reg[4 + r] * vertex_y;
            prod[r][2] = mat_reg[8 + r] * vertex_z;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[r][c] <= prod[r][c][2*COORD_W-1:16];
                end
                tr_reg[r] <= mat_reg[12 + r];
            end
        end
    end

    // Stage 2: row sums
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int r = 0; r < 4; r++)
            begin
                clip_reg[r] <= CLIP_W'(prod_reg[r][0]) + CLIP_W'(prod_reg[r][1])
                             + CLIP_W'(prod_reg[r][2]) + CLIP_W'(tr_reg[r]);
            end
        end
    end

    // Stage 3: viewport scale, flags
    logic signed [CLIP_W:0]  sumx, sumy, czw;
    logic signed [NUM_W-1:0] nx_next, ny_next;
    logic [COORD_W-1:0]      dw_next;
    always_comb
    begin
        sumx    = (CLIP_W+1)'(clip_reg[3]) + (CLIP_W+1)'(clip_reg[0]);
        sumy    = (CLIP_W+1)'(clip_reg[3]) - (CLIP_W+1)'(clip_reg[1]);
        czw     = (CLIP_W+1)'(clip_reg[3]) + (CLIP_W+1)'(clip_reg[2]);
        nx_next = NUM_W'(sumx) * $signed(NUM_W'({1'b0, width_reg}));
        ny_next = NUM_W'(sumy) * $signed(NUM_W'({1'b0, height_reg}));
        if (clip_reg[3] > CLIP_W'(32'sh7FFF_FFFF))
        begin
            dw_next = 32'h7FFF_FFFF;
        end
        else if (clip_reg[3] < -CLIP_W'(64'sh8000_0000))
        begin
            dw_next = 32'h8000_0000;
        end
        else
        begin
            dw_next = clip_reg[3][COORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            nx_reg     <= nx_next;
            ny_reg     <= ny_next;
            d_reg      <= DEN_W'({clip_reg[3][CLIP_W-2:0], 1'b0});
            behind_reg <= clip_reg[3] < W_MIN_Q;
            nc_reg     <= czw[CLIP_W];
            dw_reg     <= dw_next;
        end
    end

    // Stage 4 and divider: magnitude, range check, one quotient bit per stage
    logic [NUM_W-1:0] ax, ay;
    logic [CMP_W-1:0] dlim;
    always_comb
    begin
        ax   = nx_reg[NUM_W-1] ? NUM_W'(-nx_reg) : NUM_W'(nx_reg);
        ay   = ny_reg[NUM_W-1] ? NUM_W'(-ny_reg) : NUM_W'(ny_reg);
        dlim = CMP_W'(d_reg) << QUO_W;
        div_first.rx     = ax[MAG_W-1:0];
        div_first.ry     = ay[MAG_W-1:0];
        div_first.qx     = '0;
        div_first.qy     = '0;
        div_first.d      = d_reg;
        div_first.negx   = nx_reg[NUM_W-1];
        div_first.negy   = ny_reg[NUM_W-1];
        div_first.satx   = CMP_W'(ax) >= dlim;
        div_first.saty   = CMP_W'(ay) >= dlim;
        div_first.behind = behind_reg;
        div_first.nc     = nc_reg;
        div_first.dw     = dw_reg;
    end

    logic [CMP_W-1:0] dsh [DIV_STAGES];
    always_comb
    begin
        div_next[0] = div_first;
        dsh[0] = '0;
        for (int j = 1; j < DIV_STAGES; j++)
        begin
            div_next[j] = div_reg[j-1];
            dsh[j]      = CMP_W'(div_reg[j-1].d) << (QUO_W - j);
            if (CMP_W'(div_reg[j-1].rx) >= dsh[j])
            begin
                div_next[j].rx = MAG_W'(CMP_W'(div_reg[j-1].rx) - dsh[j]);
                div_next[j].qx[QUO_W-j] = 1'b1;
            end
            if (CMP_W'(div_reg[j-1].ry) >= dsh[j])
            begin
                div_next[j].ry = MAG_W'(CMP_W'(div_reg[j-1].ry) - dsh[j]);
                div_next[j].qy[QUO_W-j] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            if (en[DIV0 + j])
            begin
                div_reg[j] <= div_next[j];
            end
        end
    end

    // Output stage: sign, saturate, behind-eye override
    vps_div_t         last;
    logic signed [15:0] sx_next, sy_next;
    always_comb
    begin
        last = div_reg[DIV_STAGES-1];
        if (last.satx)
        begin
            sx_next = last.negx ? 16'sh8000 : 16'sh7FFF;
        end
        else
        begin
            sx_next = last.negx ? -$signed({1'b0, last.qx}) : $signed({1'b0, last.qx});
        end
        if (last.saty)
        begin
            sy_next = last.negy ? 16'sh8000 : 16'sh7FFF;
        end
        else
        begin
            sy_next = last.negy ? -$signed({1'b0, last.qy}) : $signed({1'b0, last.qy});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[OUTS])
        begin
            sx_reg  <= last.behind ? '0 : sx_next;
            sy_reg  <= last.behind ? '0 : sy_next;
            dwo_reg <= last.behind ? '0 : $signed(last.dw);
            bh_reg  <= last.behind;
            nco_reg <= last.behind ? 1'b0 : last.nc;
        end
    end

    assign out_valid   = v_reg[OUTS];
    assign screen_x    = sx_reg;
    assign screen_y    = sy_reg;
    assign depth_w     = dwo_reg;
    assign behind_flag = bh_reg;
    assign near_clip   = nco_reg;

    a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && behind_flag |-> screen_x == 0 && screen_y == 0 && depth_w == 0)
        else $error("behind result carries nonzero fields");

    a_behind_nc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && near_clip |-> !behind_flag)
        else $error("near clip set on behind result");

    a_xform_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command == CMD_XFORM |=> v_reg[0])
        else $error("accepted transform did not enter pipeline");

    a_load_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command == CMD_LOAD |=> !v_reg[0])
        else $error("coefficient load entered pipeline");

endmodule

// ===== dv/vps_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for vertex_projection_to_screen: watches config, input and output channels.
// Keeps its own matrix and viewport and checks each projected vertex; depends on vps_pkg.
module vps_checker
    import vps_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [SIZE_W-1:0]         cfg_data,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic                      command,
    input  logic [3:0]                coef_index,
    input  logic signed [COORD_W-1:0] coef_value,
    input  logic signed [COORD_W-1:0] vertex_x,
    input  logic signed [COORD_W-1:0] vertex_y,
    input  logic signed [COORD_W-1:0] vertex_z,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic signed [15:0]        screen_x,
    input  logic signed [15:0]        screen_y,
    input  logic signed [COORD_W-1:0] depth_w,
    input  logic                      behind_flag,
    input  logic                      near_clip,
    output int                        mismatch_count,
    output int                        pending_count
);

    typedef struct packed {
        logic signed [15:0]  sx;
        logic signed [15:0]  sy;
        logic signed [31:0]  dw;
        logic                behind;
        logic                nc;
    } screen_point_t;

    localparam longint BEHIND_LIMIT = 656;

    int                 view_matrix [16];
    logic [SIZE_W-1:0]  view_width;
    logic [SIZE_W-1:0]  view_height;
    screen_point_t      expected_points [$];

    function automatic longint clip_row(int row, int x, int y, int z);
        return ((longint'(view_matrix[row]) * longint'(x)) >>> 16)
             + ((longint'(view_matrix[4 + row]) * longint'(y)) >>> 16)
             + ((longint'(view_matrix[8 + row]) * longint'(z)) >>> 16)
             + longint'(view_matrix[12 + row]);
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic screen_point_t project_vertex(int x, int y, int z);
        screen_point_t p;
        longint cx;
        longint cy;
        longint cz;
        longint w;
        cx = clip_row(0, x, y, z);
        cy = clip_row(1, x, y, z);
        cz = clip_row(2, x, y, z);
        w  = clip_row(3, x, y, z);
        p = '0;
        if (w < BEHIND_LIMIT)
        begin
            p.behind = 1'b1;
            return p;
        end
        p.sx = 16'(clamp(((w + cx) * longint'(view_width)) / (2 * w), -32768, 32767));
        p.sy = 16'(clamp(((w - cy) * longint'(view_height)) / (2 * w), -32768, 32767));
        p.dw = 32'(clamp(w, -64'sd2147483648, 64'sd2147483647));
        p.nc = (cz + w < 0);
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        screen_point_t want;
        screen_point_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                view_matrix[i] = (i % 5 == 0) ? int'(Q_ONE) : 0;
            view_width     = WIDTH_RESET;
            view_height    = HEIGHT_RESET;
            mismatch_count = 0;
            expected_points.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{screen_x, screen_y, depth_w, behind_flag, near_clip};
                if (expected_points.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected result sx=%0d sy=%0d dw=%0d b=%0b nc=%0b",
                                 $realtime, got.sx, got.sy, got.dw, got.behind, got.nc);
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $write("%0t: mismatch exp sx=%0d sy=%0d dw=%0d b=%0b nc=%0b",
                                   $realtime, want.sx, want.sy, want.dw, want.behind,
                                   want.nc);
                            $display(" / act sx=%0d sy=%0d dw=%0d b=%0b nc=%0b",
                                     got.sx, got.sy, got.dw, got.behind, got.nc);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (command == CMD_LOAD)
                    view_matrix[coef_index] = coef_value;
                else
                    expected_points.insert(expected_points.size(),
                                           project_vertex(vertex_x, vertex_y, vertex_z));
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_SCREEN_WIDTH)
                    view_width = cfg_data;
                else
                    view_height = cfg_data;
            end
        end
        pending_count = expected_points.size();
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the vertex_projection_to_screen testbench: clock, reset, stimulus and verdict.
// Depends on vps_pkg, the block and vps_checker.
module tb_top;
    import vps_pkg::*;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic                      cfg_index = REG_SCREEN_WIDTH;
    logic [SIZE_W-1:0]         cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      command = CMD_LOAD;
    logic [3:0]                coef_index = '0;
    logic signed [COORD_W-1:0] coef_value = '0;
    logic signed [COORD_W-1:0] vertex_x = '0;
    logic signed [COORD_W-1:0] vertex_y = '0;
    logic signed [COORD_W-1:0] vertex_z = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [15:0]        screen_x;
    logic signed [15:0]        screen_y;
    logic signed [COORD_W-1:0] depth_w;
    logic                      behind_flag;
    logic                      near_clip;
    int                        mismatch_count;
    int                        pending_count;
    int                        burst_left = 0;

    localparam int ONE  = 65536;
    localparam int IMAX = 32'h7FFF_FFFF;
    localparam int IMIN = 32'h8000_0000;

    always #1 clk = ~clk;

    vertex_projection_to_screen i_dut (.*);

    vps_checker i_checker (.*);

    initial
    begin
        #1000000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_item(logic cmd, logic [3:0] idx, int val, int x, int y, int z);
        int gap;
        in_valid   <= 1'b1;
        command    <= cmd;
        coef_index <= idx;
        coef_value <= val;
        vertex_x   <= x;
        vertex_y   <= y;
        vertex_z   <= z;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic load_coef(logic [3:0] idx, int val);
        send_item(CMD_LOAD, idx, val, $urandom, $urandom, $urandom);
    endtask

    task automatic send_vertex(int x, int y, int z);
        send_item(CMD_XFORM, 4'($urandom), $urandom, x, y, z);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [SIZE_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int small_q(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int rand_coord();
        return ($urandom_range(0, 9) < 7) ? small_q(16 * ONE) : int'($urandom);
    endfunction

    task automatic load_view_matrix();
        for (int i = 0; i < 16; i++)
        begin
            if (i == 15)
                load_coef(4'(i), int'($urandom_range(2 * ONE, 64 * ONE)));
            else if (i % 5 == 0)
                load_coef(4'(i), ONE + small_q(ONE));
            else
                load_coef(4'(i), small_q(ONE / 2));
        end
    endtask

    task automatic random_items(int count);
        int roll;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                load_view_matrix();
            else if (roll < 10)
                load_coef(4'($urandom), small_q(4 * ONE));
            else if (roll < 13)
                load_coef(4'($urandom), int'($urandom));
            else
                send_vertex(rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    task automatic directed_items();
        send_vertex(0, 0, 0);
        send_vertex(ONE / 2, -ONE / 4, -ONE / 2);
        send_vertex(IMAX, IMAX, IMAX);
        send_vertex(IMIN, IMIN, IMIN);
        send_vertex(0, 0, -2 * ONE);
        send_vertex(1000 * ONE, -1000 * ONE, 0);
        load_coef(4'd15, 655);
        send_vertex(ONE, ONE, ONE);
        load_coef(4'd15, 656);
        send_vertex(ONE, ONE, ONE);
        load_coef(4'd15, 0);
        send_vertex(0, 0, 0);
        load_coef(4'd3, IMAX);
        load_coef(4'd15, IMAX);
        send_vertex(IMAX, 0, 0);
        load_coef(4'd3, IMIN);
        send_vertex(IMAX, 0, 0);
        load_coef(4'd3, 0);
        load_coef(4'd15, ONE);
        send_vertex(-ONE, ONE, 0);
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            out_ready <= 1'b0;
            if (rst_n)
                break;
        end
        repeat (200) @(posedge clk);
        repeat (400) @(posedge clk);
        forever
        begin
            int mode;
            int span;
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 200);
            for (int c = 0; c < span; c++)
            begin
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 1) == 1);
                    2: out_ready <= (c % 4 != 0);
                    default: out_ready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int widths  [5] = '{1, 4096, 0, 8191, 0};
        int heights [5] = '{1, 4096, 8191, 0, 0};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_items();
        random_items(200);
        for (int p = 0; p < 5; p++)
        begin
            drain();
            if (p == 4)
            begin
                write_cfg(REG_SCREEN_WIDTH, SIZE_W'($urandom_range(1, 4096)));
                write_cfg(REG_SCREEN_HEIGHT, SIZE_W'($urandom_range(1, 4096)));
            end
            else
            begin
                write_cfg(REG_SCREEN_WIDTH, SIZE_W'(widths[p]));
                write_cfg(REG_SCREEN_HEIGHT, SIZE_W'(heights[p]));
            end
            random_items(160);
        end
        drain();
        if (mismatch_count == 0 && pending_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== vertex_projection_to_screen.f =====
rtl/core/vps_pkg.sv
rtl/core/vertex_projection_to_screen.sv
dv/vps_checker.sv
dv/tb_top.sv
